>>> design/abep_pkg.sv
package abep_pkg;

   // size limits
   localparam int MaxWidth  = 2048;
   localparam int MaxHeight = 2048;

   localparam int CfgW   = 12;
   localparam int DimW   = $clog2(MaxWidth) + 1;
   localparam int ColW   = $clog2(MaxWidth);
   localparam int CntW   = $clog2(MaxWidth * MaxHeight) + 1;
   // raw ring holds more than two full lines plus the window overhang
   localparam int RawAw  = $clog2(4 * MaxWidth);
   localparam int QDepth = 4;
   localparam int QAw    = $clog2(QDepth);

   localparam logic [31:0] ALPHA_MASK = 32'hff000000;
   localparam logic [31:0] RED_MASK   = 32'h000000ff;
   localparam logic [31:0] GREEN_MASK = 32'h0000ff00;
   localparam logic [31:0] BLUE_MASK  = 32'h00ff0000;

   typedef logic [31:0] pixel_type;

   typedef enum logic [1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_SRC_WIDTH,
      CSR_SRC_HEIGHT
   } csr_index_type;

   // effective sizes
   typedef struct packed {
      logic [DimW-1:0] w;
      logic [DimW-1:0] h;
      logic [DimW-1:0] sw;
      logic [DimW-1:0] sh;
   } cfg_type;

   // one output pixel to compute
   typedef struct packed {
      logic [RawAw-1:0] addr;
      logic [DimW-1:0]  ox;
      logic [DimW-1:0]  oy;
      logic             last;
   } job_type;

   typedef struct packed {
      logic             en;
      logic [RawAw-1:0] addr;
      pixel_type        data;
   } raw_wr_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_LAST,
      BK_DIV,
      BK_OUT
   } back_state_type;

   // clamp a size register to 1..limit
   function automatic logic [DimW-1:0] eff_size(input logic [CfgW-1:0] v,
                                                input logic [DimW-1:0] lim);
      logic [DimW-1:0] r;
      if (v == '0) r = DimW'(1);
      else if (DimW'(v) > lim) r = lim;
      else r = DimW'(v);
      return r;
   endfunction

   // ceil(2^16 / n), exact floor division for sums below 2^11
   function automatic logic [16:0] recip(input logic [3:0] n);
      logic [16:0] r;
      case (n)
         4'd1:    r = 17'd65536;
         4'd2:    r = 17'd32768;
         4'd3:    r = 17'd21846;
         4'd4:    r = 17'd16384;
         4'd5:    r = 17'd13108;
         4'd6:    r = 17'd10923;
         4'd7:    r = 17'd9363;
         4'd8:    r = 17'd8192;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

endpackage

>>> design/abep_req_if.sv
interface abep_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] pixel_in;

   modport source(output valid, req_type, pixel_in, input ready);
   modport sink(input valid, req_type, pixel_in, output ready);
endinterface

>>> design/abep_rsp_if.sv
interface abep_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_out;
   logic        last_pixel;

   modport source(output valid, pixel_out, last_pixel, input ready);
   modport sink(input valid, pixel_out, last_pixel, output ready);
endinterface

>>> design/abep_front.sv
module abep_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  abep_pkg::csr_index_type       csr_index,
   input  logic [abep_pkg::CfgW-1:0]     csr_wdata,
   abep_req_if.sink                      req,
   input  logic                          q_full,
   output abep_pkg::cfg_type             cfg,
   output abep_pkg::raw_wr_type          raw_wr,
   output abep_pkg::job_type             job,
   output logic                          job_push
);
   import abep_pkg::*;

   logic [CfgW-1:0] img_w_ff, img_h_ff, src_w_ff, src_h_ff;
   logic [CntW-1:0] have_ff, have_in, out_cnt_ff;
   logic [DimW-1:0] ox_ff, oy_ff;
   logic [RawAw-1:0] base_ff;
   logic [DimW-1:0] w, h;
   logic [CntW-1:0] total;
   logic            accept, is_pix, emit, last;

   assign w     = eff_size(img_w_ff, DimW'(MaxWidth));
   assign h     = eff_size(img_h_ff, DimW'(MaxHeight));
   assign total = CntW'(w * h);

   assign cfg.w  = w;
   assign cfg.h  = h;
   assign cfg.sw = DimW'(src_w_ff);
   assign cfg.sh = DimW'(src_h_ff);

   // classify the incoming word
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign is_pix    = (req.req_type == 1'b0) && (have_ff < total);
   assign have_in   = have_ff + CntW'(accept && is_pix);
   assign emit      = accept && (out_cnt_ff < total) &&
                      ((have_in == total) ||
                       (have_in >= out_cnt_ff + CntW'(w) + CntW'(2)));
   assign last      = (out_cnt_ff + CntW'(1)) == total;

   // each frame lands after the previous one in the ring, so queued jobs
   // of a finished frame still see their pixels
   assign raw_wr.en   = accept && is_pix;
   assign raw_wr.addr = base_ff + have_ff[RawAw-1:0];
   assign raw_wr.data = req.pixel_in;

   assign job_push = emit;
   assign job.addr = base_ff + out_cnt_ff[RawAw-1:0];
   assign job.ox   = ox_ff;
   assign job.oy   = oy_ff;
   assign job.last = last;

   // configuration and position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff   <= CfgW'(64);
         img_h_ff   <= CfgW'(64);
         src_w_ff   <= CfgW'(64);
         src_h_ff   <= CfgW'(64);
         have_ff    <= '0;
         out_cnt_ff <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         base_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  img_w_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: img_h_ff <= csr_wdata;
            CSR_SRC_WIDTH:    src_w_ff <= csr_wdata;
            CSR_SRC_HEIGHT:   src_h_ff <= csr_wdata;
            default:          img_w_ff <= img_w_ff;
         endcase
         have_ff    <= '0;
         out_cnt_ff <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
      end else if (emit && last) begin
         have_ff    <= '0;
         out_cnt_ff <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         base_ff    <= base_ff + total[RawAw-1:0];
      end else begin
         have_ff <= have_in;
         if (emit) begin
            out_cnt_ff <= out_cnt_ff + CntW'(1);
            if (ox_ff + DimW'(1) >= w) begin
               ox_ff <= '0;
               oy_ff <= oy_ff + DimW'(1);
            end else begin
               ox_ff <= ox_ff + DimW'(1);
            end
         end
      end
   end

endmodule

>>> design/abep_queue.sv
module abep_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  abep_pkg::job_type push_job,
   input  logic              pop,
   output abep_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);
   import abep_pkg::*;

   job_type          slot_ff [QDepth];
   logic [QAw-1:0]   wp_ff, rp_ff;
   logic [QAw:0]     cnt_ff;

   assign full     = cnt_ff == (QAw+1)'(QDepth);
   assign empty    = cnt_ff == '0;
   assign head_job = slot_ff[rp_ff];

   // payload slots
   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_job;
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + QAw'(1);
         if (pop)  rp_ff <= rp_ff + QAw'(1);
         cnt_ff <= cnt_ff + (QAw+1)'(push) - (QAw+1)'(pop);
      end
   end

endmodule

>>> design/abep_back.sv
module abep_back (
   input  logic                 clock,
   input  logic                 reset,
   input  abep_pkg::cfg_type    cfg,
   input  abep_pkg::raw_wr_type raw_wr,
   input  abep_pkg::job_type    head_job,
   input  logic                 q_empty,
   output logic                 pop,
   abep_rsp_if.source           rsp
);
   import abep_pkg::*;

   pixel_type       raw_mem [2**RawAw];
   pixel_type       fix_mem [MaxWidth];

   back_state_type  state_ff, state_in;
   job_type         job_ff;
   logic [1:0]      dx_ff, dy_ff;
   logic [RawAw-1:0] rowoff_ff, rd_addr;
   pixel_type       rdata_ff, fix_rdata_ff, self_ff;
   logic            rd_vld_ff, rd_use_ff, rd_ctr_ff;
   logic [10:0]     sum_r_ff, sum_g_ff, sum_b_ff;
   logic [3:0]      n_ff;
   logic [27:0]     prod_r_ff, prod_g_ff, prod_b_ff;
   logic            rsp_valid_ff, rsp_last_ff;
   pixel_type       rsp_pix_ff;

   logic            rd_en, fix_re, load, xok, yok, tiny_img, copy_en;
   logic            copy_row, copy_col;
   logic [ColW-1:0] fix_addr;
   logic [DimW-1:0] sw_m1;
   pixel_type       avg_px, base_px, px;

   // window position checks against the image borders
   assign xok = !(dx_ff == 2'd0 && job_ff.ox == '0) &&
                !(dx_ff == 2'd2 && ({1'b0, job_ff.ox} + (DimW+1)'(1)) >= {1'b0, cfg.w});
   assign yok = !(dy_ff == 2'd0 && job_ff.oy == '0) &&
                !(dy_ff == 2'd2 && ({1'b0, job_ff.oy} + (DimW+1)'(1)) >= {1'b0, cfg.h});
   assign rd_addr = job_ff.addr + rowoff_ff + RawAw'(dx_ff) - RawAw'(1);

   // edge copy decode
   assign tiny_img = (cfg.w < DimW'(2)) || (cfg.h < DimW'(2));
   assign copy_en  = (cfg.sw != '0) && (cfg.sh != '0) && !tiny_img;
   assign copy_row = copy_en && (cfg.sh < cfg.h) && (job_ff.oy == cfg.sh) &&
                     (job_ff.ox < cfg.sw);
   assign copy_col = copy_en && (cfg.sw < cfg.w) && (job_ff.ox == cfg.sw) &&
                     (job_ff.oy <= cfg.sh);
   assign sw_m1    = cfg.sw - DimW'(1);
   assign fix_addr = copy_col ? sw_m1[ColW-1:0] : job_ff.ox[ColW-1:0];

   // result select
   assign avg_px  = {8'h00, prod_b_ff[23:16], prod_g_ff[23:16], prod_r_ff[23:16]};
   assign base_px = ((self_ff & ALPHA_MASK) != '0 || n_ff == '0 || tiny_img) ?
                    self_ff : avg_px;
   assign px      = (copy_col || copy_row) ? fix_rdata_ff : base_px;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (!q_empty) state_in = BK_READ;
         BK_READ: if (dx_ff == 2'd2 && dy_ff == 2'd2) state_in = BK_LAST;
         BK_LAST: state_in = BK_DIV;
         BK_DIV:  state_in = BK_OUT;
         BK_OUT:  if (!rsp_valid_ff || rsp.ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop    = 1'b0;
      rd_en  = 1'b0;
      fix_re = 1'b0;
      load   = 1'b0;
      case (state_ff)
         BK_IDLE: pop = !q_empty;
         BK_READ: begin
            rd_en  = 1'b1;
            fix_re = (dx_ff == 2'd0) && (dy_ff == 2'd0);
         end
         BK_OUT:  load = !rsp_valid_ff || rsp.ready;
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else       state_ff <= state_in;
   end

   // raw line ring
   always_ff @(posedge clock) begin
      if (raw_wr.en) raw_mem[raw_wr.addr] <= raw_wr.data;
      if (rd_en)     rdata_ff <= raw_mem[rd_addr];
   end

   // last emitted pixel per column
   always_ff @(posedge clock) begin
      if (load)   fix_mem[job_ff.ox[ColW-1:0]] <= px;
      if (fix_re) fix_rdata_ff <= fix_mem[fix_addr];
   end

   // window walk
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff    <= head_job;
         dx_ff     <= 2'd0;
         dy_ff     <= 2'd0;
         rowoff_ff <= RawAw'(0) - RawAw'(cfg.w);
      end else if (rd_en) begin
         if (dx_ff == 2'd2) begin
            dx_ff     <= 2'd0;
            dy_ff     <= dy_ff + 2'd1;
            rowoff_ff <= rowoff_ff + RawAw'(cfg.w);
         end else begin
            dx_ff <= dx_ff + 2'd1;
         end
      end
   end

   // read tags
   always_ff @(posedge clock) begin
      if (reset) rd_vld_ff <= 1'b0;
      else       rd_vld_ff <= rd_en;
      rd_use_ff <= xok && yok;
      rd_ctr_ff <= (dx_ff == 2'd1) && (dy_ff == 2'd1);
   end

   // accumulate opaque neighbors
   always_ff @(posedge clock) begin
      if (pop) begin
         sum_r_ff <= '0;
         sum_g_ff <= '0;
         sum_b_ff <= '0;
         n_ff     <= '0;
      end else if (rd_vld_ff) begin
         if (rd_use_ff && (rdata_ff & ALPHA_MASK) != '0) begin
            sum_r_ff <= sum_r_ff + 11'(rdata_ff[7:0]);
            sum_g_ff <= sum_g_ff + 11'(rdata_ff[15:8]);
            sum_b_ff <= sum_b_ff + 11'(rdata_ff[23:16]);
            n_ff     <= n_ff + 4'd1;
         end
         if (rd_ctr_ff) self_ff <= rdata_ff;
      end
   end

   // divide by count through reciprocal
   always_ff @(posedge clock) begin
      if (state_ff == BK_DIV) begin
         prod_r_ff <= sum_r_ff * recip(n_ff);
         prod_g_ff <= sum_g_ff * recip(n_ff);
         prod_b_ff <= sum_b_ff * recip(n_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         rsp_pix_ff  <= px;
         rsp_last_ff <= job_ff.last;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_out  = rsp_pix_ff;
   assign rsp.last_pixel = rsp_last_ff;

endmodule

>>> design/alpha_bleed_edge_pad_filter.sv
// Timing: pixel p is computed once pixel p+width+1 (or the last pixel) is in,
//   then passes the back end states IDLE, READ, LAST, DIV and OUT.
// Flow: the back end works on one job at a time, set by the nine reads of
//   the raw line ring; the front takes one word per cycle until 4 jobs queue.
// Reset: synchronous, active high; sizes return to 64, counters clear,
//   line stores keep their contents.
module alpha_bleed_edge_pad_filter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  abep_pkg::csr_index_type   csr_index,
   input  logic [abep_pkg::CfgW-1:0] csr_wdata,
   abep_req_if.sink                  req_bus,
   abep_rsp_if.source                rsp_bus
);
   import abep_pkg::*;

   cfg_type    cfg;
   raw_wr_type raw_wr;
   job_type    push_job, head_job;
   logic       job_push, q_full, q_empty, pop;

   abep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .q_full    (q_full),
      .cfg       (cfg),
      .raw_wr    (raw_wr),
      .job       (push_job),
      .job_push  (job_push)
   );

   abep_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   abep_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .raw_wr   (raw_wr),
      .head_job (head_job),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp      (rsp_bus)
   );

endmodule

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import abep_pkg::*;

   localparam int RingDepth  = 2 * MaxWidth + 4;
   localparam int IdleLimit  = 6000;
   localparam int SettleWait = 40;

   // predicts the fixed image and holds the pixels still owed by the block
   class bleed_scoreboard;
      typedef struct {
         logic [31:0] pix;
         logic        last;
      } fixed_word_type;

      logic [11:0] size_reg[4];
      logic [31:0] raw_ring[RingDepth];
      logic [31:0] fixed_col[MaxWidth];
      int unsigned in_col, in_row, out_cnt;
      fixed_word_type owed[$];
      int fails;

      function new();
         foreach (size_reg[i]) size_reg[i] = 12'd64;
         foreach (raw_ring[i]) raw_ring[i] = '0;
         foreach (fixed_col[i]) fixed_col[i] = '0;
         in_col = 0; in_row = 0; out_cnt = 0; fails = 0;
      endfunction

      task report(string msg);
         $display("ERROR %0t: %s", $time, msg);
         fails++;
      endtask

      function int unsigned clamp(logic [11:0] v, int unsigned lim);
         if (v == 0) return 1;
         return (v > lim) ? lim : v;
      endfunction

      function int unsigned img_w();
         return clamp(size_reg[CSR_IMAGE_WIDTH], MaxWidth);
      endfunction

      function int unsigned img_h();
         return clamp(size_reg[CSR_IMAGE_HEIGHT], MaxHeight);
      endfunction

      function void write_reg(csr_index_type idx, logic [11:0] v);
         size_reg[idx] = v;
         in_col = 0; in_row = 0; out_cnt = 0;
      endfunction

      function bit mid_frame();
         return in_col != 0 || in_row != 0 || out_cnt != 0;
      endfunction

      function logic [31:0] raw_at(int unsigned idx);
         return raw_ring[idx % RingDepth];
      endfunction

      // average of opaque pixels in the clipped 3x3 window, for clear pixels only
      function logic [31:0] bleed(int unsigned x, int unsigned y,
                                  int unsigned w, int unsigned h);
         logic [31:0] self_px, px;
         int unsigned x0, x1, y0, y1, n, r, g, b;
         self_px = raw_at(y * w + x);
         if ((self_px & ALPHA_MASK) != 0) return self_px;
         x0 = (x > 0) ? x - 1 : 0;
         y0 = (y > 0) ? y - 1 : 0;
         x1 = (x + 1 < w) ? x + 1 : w - 1;
         y1 = (y + 1 < h) ? y + 1 : h - 1;
         n = 0; r = 0; g = 0; b = 0;
         for (int unsigned yy = y0; yy <= y1; yy++) begin
            for (int unsigned xx = x0; xx <= x1; xx++) begin
               px = raw_at(yy * w + xx);
               if ((px & ALPHA_MASK) != 0) begin
                  r += px[7:0];
                  g += px[15:8];
                  b += px[23:16];
                  n++;
               end
            end
         end
         if (n == 0) return self_px;
         return {8'h00, 8'(b / n), 8'(g / n), 8'(r / n)};
      endfunction

      function void note_input(logic drain, logic [31:0] pix);
         int unsigned w, h, total, have, ox, oy, sw, sh;
         logic [31:0] px;
         fixed_word_type word;
         w = img_w(); h = img_h(); total = w * h;
         sw = size_reg[CSR_SRC_WIDTH]; sh = size_reg[CSR_SRC_HEIGHT];
         if (!drain && in_row < h) begin
            raw_ring[(in_row * w + in_col) % RingDepth] = pix;
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
            end
         end
         have = in_row * w + in_col;
         if (out_cnt >= total) return;
         if (!(have == total || have >= out_cnt + w + 2)) return;
         ox = out_cnt % w;
         oy = out_cnt / w;
         if (w < 2 || h < 2) begin
            px = raw_at(out_cnt);
         end else begin
            px = bleed(ox, oy, w, h);
            if (sw != 0 && sh != 0) begin
               // row copy below the source rectangle, then column copy and corner
               if (sh < h && oy == sh && ox < sw) px = fixed_col[ox];
               if (sw < w && ox == sw && oy <= sh) px = fixed_col[sw - 1];
            end
         end
         fixed_col[ox] = px;
         out_cnt++;
         word.pix = px;
         word.last = (out_cnt == total);
         if (word.last) begin
            in_col = 0; in_row = 0; out_cnt = 0;
         end
         owed.push_back(word);
      endfunction

      task check_result(logic [31:0] pix, logic last);
         fixed_word_type exp_word;
         if (owed.size() == 0) begin
            report($sformatf("unexpected word pixel=%h last=%b", pix, last));
            return;
         end
         exp_word = owed.pop_front();
         if (pix !== exp_word.pix)
            report($sformatf("pixel_out %h, expected %h", pix, exp_word.pix));
         if (last !== exp_word.last)
            report($sformatf("last_pixel %b, expected %b", last, exp_word.last));
      endtask
   endclass

   logic clock, reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [CfgW-1:0] csr_wdata;

   abep_req_if req_bus ();
   abep_rsp_if rsp_bus ();

   alpha_bleed_edge_pad_filter dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   bleed_scoreboard sb = new();

   int send_idle_pct, recv_stall_pct;
   int long_hold;
   int hold_left;
   int idle_cycles;
   int items_sent;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // receiver side: check words, random stalls, long hold-off on request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.pixel_out, rsp_bus.last_pixel);
         if (long_hold > 0 && hold_left == 0) begin
            hold_left = long_hold;
            long_hold = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("FAIL alpha_bleed_edge_pad_filter");
         $finish;
      end
   end

   function automatic logic [31:0] pick_pixel();
      case ($urandom_range(7))
         0: return 32'h00000000;
         1: return 32'hffffffff;
         2: return 32'h00ffffff;
         3, 4: return {8'h00, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(logic drain, logic [31:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.req_type <= drain;
      req_bus.pixel_in <= pix;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      sb.note_input(drain, pix);
      items_sent++;
   endtask

   // hold the sender until every owed pixel is out, then let the back end settle
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (SettleWait) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [11:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic set_sizes(logic [11:0] iw, logic [11:0] ih, logic [11:0] sw,
                            logic [11:0] sh);
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, iw);
      write_csr(CSR_IMAGE_HEIGHT, ih);
      write_csr(CSR_SRC_WIDTH, sw);
      write_csr(CSR_SRC_HEIGHT, sh);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // one image, with stray drains inside and surplus pixels in the tail
   task automatic send_image(int noise_pct);
      int unsigned total;
      total = sb.img_w() * sb.img_h();
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(99) < noise_pct) send_word(1'b1, $urandom);
         send_word(1'b0, pick_pixel());
      end
      while (sb.mid_frame()) begin
         if ($urandom_range(99) < noise_pct) send_word(1'b0, pick_pixel());
         else send_word(1'b1, $urandom);
      end
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
         default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
   endtask

   initial begin
      int unsigned w, h;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.req_type = 1'b0;
      req_bus.pixel_in = '0;
      rsp_bus.ready = 1'b0;
      send_idle_pct = 0; recv_stall_pct = 0;
      long_hold = 0; hold_left = 0; idle_cycles = 0; items_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: column and row copy, corner, drains before the image is in
      set_sizes(12'd4, 12'd3, 12'd2, 12'd2);
      send_word(1'b1, 32'hffffffff);
      send_word(1'b0, 32'h00000000);
      send_word(1'b0, 32'hff0000ff);
      send_word(1'b0, 32'hff00ff00);
      send_word(1'b0, 32'h00ffffff);
      send_word(1'b0, 32'hffff0000);
      send_word(1'b0, 32'hffffffff);
      send_word(1'b1, 32'h0);
      for (int i = 0; i < 6; i++) send_word(1'b0, 32'h00123456);
      while (sb.mid_frame()) send_word(1'b0, 32'hffffffff);
      // one-pixel-wide, one-pixel-high, zero sizes, sources out of range
      set_sizes(12'd1, 12'd5, 12'd1, 12'd5);
      send_image(0);
      set_sizes(12'd3, 12'd1, 12'd1, 12'd1);
      send_image(0);
      set_sizes(12'd0, 12'd0, 12'd0, 12'd0);
      send_image(0);
      set_sizes(12'd3, 12'd3, 12'd4095, 12'd4095);
      send_image(20);
      set_sizes(12'd4, 12'd3, 12'd0, 12'd1);
      send_image(0);
      // widest image, saturated width
      set_sizes(12'd4095, 12'd1, 12'd2048, 12'd1);
      send_image(0);

      // back pressure: receiver holds off while the sender keeps offering
      set_sizes(12'd8, 12'd6, 12'd6, 12'd4);
      long_hold = 400;
      send_image(0);

      // random sizes, all small
      items_sent = 0;
      for (int phase = 0; items_sent < 500; phase++) begin
         set_idling(phase % 4);
         w = $urandom_range(1, 10);
         h = $urandom_range(1, 7);
         if ($urandom_range(9) == 0)
            set_sizes(12'(w), 12'(h), 12'($urandom_range(0, w + 1)),
                      12'($urandom_range(0, h + 1)));
         else
            set_sizes(12'(w), 12'(h), 12'($urandom_range(1, w)), 12'($urandom_range(1, h)));
         send_image(($urandom_range(3) == 0) ? 15 : 0);
      end

      wait_drained();
      if (sb.fails == 0)
         $display("PASS alpha_bleed_edge_pad_filter");
      else
         $display("FAIL alpha_bleed_edge_pad_filter");
      $finish;
   end
endmodule

>>> files.f
design/abep_pkg.sv
design/abep_req_if.sv
design/abep_rsp_if.sv
design/abep_front.sv
design/abep_queue.sv
design/abep_back.sv
design/alpha_bleed_edge_pad_filter.sv
test/testbench.sv
